[src/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
	`SMC_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	`SMC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[src/smc_pkg.sv]
`default_nettype none
package smc_pkg;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_ABSENT = 2'd2;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_INCR,
		OP_DECR
	} cell_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic               cmp;
		logic signed [31:0] value;
		logic [15:0]        occurrences;
		cell_op_t           op;
	} cell_ctrl_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] lim);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, lim}) ? lim : s[31:0];
	endfunction

endpackage
`default_nettype wire

[src/smc_req_if.sv]
`default_nettype none
interface smc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] value;
	logic [15:0]        occurrences;

	modport source (output valid, mode, value, occurrences, input ready);
	modport sink   (input valid, mode, value, occurrences, output ready);
endinterface
`default_nettype wire

[src/smc_rsp_if.sv]
`default_nettype none
interface smc_rsp_if;
	logic               valid;
	logic               ready;
	logic               present;
	logic [15:0]        value_count;
	logic [31:0]        total_count;
	logic signed [31:0] smallest_value;
	logic               is_empty;
	logic [1:0]         status;

	modport source (output valid, present, value_count, total_count, smallest_value, is_empty,
		status, input ready);
	modport sink   (input valid, present, value_count, total_count, smallest_value, is_empty,
		status, output ready);
endinterface
`default_nettype wire

[src/smc_cell.sv]
`default_nettype none
module smc_cell #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire smc_pkg::cell_ctrl_t    ctrl,
	input  wire                         prev_lt,
	input  wire                         left_valid,
	input  wire signed [31:0]           left_value,
	input  wire [COUNT_WIDTH-1:0]       left_count,
	input  wire                         right_valid,
	input  wire signed [31:0]           right_value,
	input  wire [COUNT_WIDTH-1:0]       right_count,
	output logic                        lt,
	output logic                        eq,
	output logic                        valid,
	output logic signed [31:0]          value,
	output logic [COUNT_WIDTH-1:0]      count
);

	localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic                   valid_q;
	logic                   lt_q;
	logic                   eq_q;
	logic signed [31:0]     value_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   at_pos;
	logic [COUNT_WIDTH-1:0] inc_count;
	logic [COUNT_WIDTH-1:0] new_count;

	// first cell not below the request value is the insertion point
	assign at_pos    = !lt_q && prev_lt;
	assign inc_count = COUNT_WIDTH'(smc_pkg::sat_add(32'(count_q), 32'(ctrl.occurrences),
		CountMax));
	assign new_count = COUNT_WIDTH'(smc_pkg::sat_add(32'd0, 32'(ctrl.occurrences), CountMax));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (ctrl.cmp) begin
				lt_q <= valid_q && (value_q < $signed(ctrl.value));
				eq_q <= valid_q && (value_q == $signed(ctrl.value));
			end
			unique case (ctrl.op)
				smc_pkg::OP_INSERT: begin
					if (!lt_q) valid_q <= at_pos ? 1'b1 : left_valid;
				end
				smc_pkg::OP_DELETE: begin
					if (!lt_q) valid_q <= right_valid;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			smc_pkg::OP_INSERT: begin
				if (at_pos) begin
					value_q <= $signed(ctrl.value);
					count_q <= new_count;
				end else if (!lt_q) begin
					value_q <= left_value;
					count_q <= left_count;
				end
			end
			smc_pkg::OP_DELETE: begin
				if (!lt_q) begin
					value_q <= right_value;
					count_q <= right_count;
				end
			end
			smc_pkg::OP_INCR: begin
				if (eq_q) count_q <= inc_count;
			end
			smc_pkg::OP_DECR: begin
				if (eq_q) count_q <= count_q - COUNT_WIDTH'(1);
			end
			default: ;
		endcase
	end

	assign lt    = lt_q;
	assign eq    = eq_q;
	assign valid = valid_q;
	assign value = value_q;
	assign count = count_q;

endmodule
`default_nettype wire

[src/sorted_multiset_counter_core.sv]
`default_nettype none
`include "assert_macros.svh"
// Sorted (value, count) table over a row of CAPACITY cells.
// req channel: mode (add / remove one / lookup), value, occurrences.
// rsp channel: present, value_count, total_count, smallest_value, is_empty, status;
// exactly one response per request, in order.
// Timing: a request is taken in the idle phase; at that edge every cell compares
// its entry against the value. The update phase follows: once no older response
// waits untaken, it commits the update across the row (cells shift toward or away
// from the insertion point in one step) and loads the response register. No new
// request is taken until that commit returns the block to the idle phase.
// A request may be accepted while a response waits; its commit then stalls until
// the response is taken, and the table stays unchanged during the stall.
// total_count, smallest_value and is_empty come straight from the table registers.
// Reset empties the table and clears the total; no clearing pass is needed, so
// requests are accepted from the first cycle after reset.
module sorted_multiset_counter_core #(
	parameter int CAPACITY    = 64,
	parameter int COUNT_WIDTH = 16
) (
	input wire        clk,
	input wire        arst_n,
	smc_req_if.sink   req,
	smc_rsp_if.source rsp
);

	localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	typedef enum logic {PH_IDLE, PH_UPD} phase_t;

	phase_t                 phase_q;
	logic                   rsp_valid_q;
	logic                   present_q;
	logic [15:0]            value_count_q;
	logic [1:0]             status_q;
	logic [31:0]            total_q;
	logic [1:0]             mode_q;
	logic signed [31:0]     req_value_q;
	logic [15:0]            occ_q;

	smc_pkg::cell_ctrl_t    ctrl;
	logic [CAPACITY-1:0]    lt_v;
	logic [CAPACITY-1:0]    eq_v;
	logic [CAPACITY-1:0]    valid_v;
	logic signed [31:0]     value_a [CAPACITY];
	logic [COUNT_WIDTH-1:0] cnt_a [CAPACITY];

	logic                   accept;
	logic                   commit;
	logic                   found;
	logic                   full;
	logic [31:0]            old_cnt;
	smc_pkg::cell_op_t      op_d;
	logic                   present_d;
	logic [31:0]            cnt_d;
	logic [1:0]             status_d;
	logic [31:0]            total_d;

	assign req.ready = (phase_q == PH_IDLE);
	assign accept    = req.valid && req.ready;
	assign commit    = (phase_q == PH_UPD) && (!rsp_valid_q || rsp.ready);
	assign found     = |eq_v;
	assign full      = valid_v[CAPACITY-1];

	always_comb begin
		old_cnt = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (eq_v[i]) old_cnt = old_cnt | 32'(cnt_a[i]);
		end
	end

	always_comb begin
		op_d      = smc_pkg::OP_HOLD;
		present_d = found;
		cnt_d     = old_cnt;
		status_d  = smc_pkg::STATUS_OK;
		total_d   = total_q;
		unique case (mode_q)
			smc_pkg::MODE_ADD: begin
				if (found) begin
					op_d    = smc_pkg::OP_INCR;
					cnt_d   = smc_pkg::sat_add(old_cnt, 32'(occ_q), CountMax);
					total_d = smc_pkg::sat_add(total_q, 32'(occ_q), '1);
				end else if (occ_q != '0) begin
					if (full) begin
						status_d = smc_pkg::STATUS_FULL;
					end else begin
						op_d      = smc_pkg::OP_INSERT;
						present_d = 1'b1;
						cnt_d     = smc_pkg::sat_add(32'd0, 32'(occ_q), CountMax);
						total_d   = smc_pkg::sat_add(total_q, 32'(occ_q), '1);
					end
				end
			end
			smc_pkg::MODE_REMOVE: begin
				if (!found) begin
					status_d = smc_pkg::STATUS_ABSENT;
				end else begin
					if (old_cnt > 32'd1) begin
						op_d  = smc_pkg::OP_DECR;
						cnt_d = old_cnt - 32'd1;
					end else begin
						op_d      = smc_pkg::OP_DELETE;
						present_d = 1'b0;
						cnt_d     = '0;
					end
					if (total_q != '0) total_d = total_q - 32'd1;
				end
			end
			smc_pkg::MODE_LOOKUP: ;
			default: ;
		endcase
	end

	always_comb begin
		ctrl.cmp         = accept;
		ctrl.value       = accept ? req.value : req_value_q;
		ctrl.occurrences = occ_q;
		ctrl.op          = commit ? op_d : smc_pkg::OP_HOLD;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= req.mode;
			req_value_q <= req.value;
			occ_q       <= req.occurrences;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			rsp_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (accept) phase_q <= PH_UPD;
					if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
				end
				PH_UPD: begin
					if (commit) begin
						phase_q       <= PH_IDLE;
						rsp_valid_q   <= 1'b1;
						present_q     <= present_d;
						value_count_q <= (cnt_d > 32'hFFFF) ? 16'hFFFF : cnt_d[15:0];
						status_q      <= status_d;
						total_q       <= total_d;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.present        = present_q;
	assign rsp.value_count    = value_count_q;
	assign rsp.status         = status_q;
	assign rsp.total_count    = total_q;
	assign rsp.is_empty       = !valid_v[0];
	assign rsp.smallest_value = valid_v[0] ? value_a[0] : 32'sd0;

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		logic                   prev_lt;
		logic                   left_valid;
		logic signed [31:0]     left_value;
		logic [COUNT_WIDTH-1:0] left_count;
		logic                   right_valid;
		logic signed [31:0]     right_value;
		logic [COUNT_WIDTH-1:0] right_count;

		if (gi == 0) begin : g_first
			assign prev_lt    = 1'b1;
			assign left_valid = 1'b0;
			assign left_value = '0;
			assign left_count = '0;
		end else begin : g_mid_l
			assign prev_lt    = lt_v[gi-1];
			assign left_valid = valid_v[gi-1];
			assign left_value = value_a[gi-1];
			assign left_count = cnt_a[gi-1];
		end

		if (gi == CAPACITY - 1) begin : g_last
			assign right_valid = 1'b0;
			assign right_value = '0;
			assign right_count = '0;
		end else begin : g_mid_r
			assign right_valid = valid_v[gi+1];
			assign right_value = value_a[gi+1];
			assign right_count = cnt_a[gi+1];
		end

		smc_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_lt    (prev_lt),
			.left_valid (left_valid),
			.left_value (left_value),
			.left_count (left_count),
			.right_valid(right_valid),
			.right_value(right_value),
			.right_count(right_count),
			.lt         (lt_v[gi]),
			.eq         (eq_v[gi]),
			.valid      (valid_v[gi]),
			.value      (value_a[gi]),
			.count      (cnt_a[gi])
		);
	end

	// occupied cells always form a prefix of the row
	for (genvar gi = 1; gi < CAPACITY; gi++) begin : g_chk
		`SMC_ASSERT_IMP(a_valid_prefix, valid_v[gi], valid_v[gi-1], "hole in occupied cells")
	end

	`SMC_ASSERT(a_eq_unique, $onehot0(eq_v), "value matched in more than one cell")

	`SMC_ASSERT_NEXT(a_stall_hold, rsp_valid_q && !rsp.ready,
		$stable(total_q) && $stable(valid_v) && $stable(rsp.smallest_value), "table changed during stall")

endmodule
`default_nettype wire
